>>> src/soit_pkg.sv
// Shared constants and the inverse square root seed table for the sphere/box test.
package soit_pkg;

    localparam int NEWTON_STEPS = 3;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } t_cfg_idx;

    // seed for 1/sqrt(m), indexed by m[31:29], Q2.30
    function automatic logic [31:0] seed_of(input logic [2:0] top);
        logic [15:0] s;
        case (top)
            3'd3:    s = 16'd49541;
            3'd4:    s = 16'd43691;
            3'd5:    s = 16'd39520;
            3'd6:    s = 16'd36353;
            3'd7:    s = 16'd33843;
            default: s = 16'd58617;
        endcase
        return {2'b00, s, 14'b0};
    endfunction

endpackage

>>> src/soit_box_if.sv
// Box request channel: valid/ready handshake with the oriented box payload.
interface soit_box_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] box_center_x, box_center_y, box_center_z;
    logic [W-1:0] axis_a_x, axis_a_y, axis_a_z;
    logic [W-1:0] axis_b_x, axis_b_y, axis_b_z;
    logic [W-1:0] axis_c_x, axis_c_y, axis_c_z;

    modport source (output valid, box_center_x, box_center_y, box_center_z,
                    axis_a_x, axis_a_y, axis_a_z, axis_b_x, axis_b_y, axis_b_z,
                    axis_c_x, axis_c_y, axis_c_z, input ready);
    modport sink   (input valid, box_center_x, box_center_y, box_center_z,
                    axis_a_x, axis_a_y, axis_a_z, axis_b_x, axis_b_y, axis_b_z,
                    axis_c_x, axis_c_y, axis_c_z, output ready);
endinterface

>>> src/soit_res_if.sv
// Result channel: valid/ready handshake with the overlap flag.
interface soit_res_if;
    logic valid;
    logic ready;
    logic overlaps;

    modport source (output valid, overlaps, input ready);
    modport sink   (input valid, overlaps, output ready);
endinterface

>>> src/soit_lane.sv
// One axis lane: projection, excess, inverse axis length and squared distance term.
module soit_lane #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W:0]   i_d [3],
    input  logic signed [W-1:0] i_u [3],
    output logic [2*W-1:0]      o_term
);
    import soit_pkg::*;

    localparam int PW  = 2*W + 1;
    localparam int SPW = 2*W + 3;
    localparam int SQW = 2*W + 2;
    localparam int XW  = 2*W + 2;
    localparam int XHW = XW - 33;
    localparam int KW  = $clog2(W + 1);
    localparam int MBW = $clog2(SQW);
    localparam int NS  = NEWTON_STEPS;
    localparam int NC  = 3*NS + 1;
    localparam int PRW = XW + 32;

    // L1: products
    logic signed [PW-1:0]  r_pd [3];
    logic signed [2*W-1:0] r_pq [3];
    // L2: dot products
    logic signed [SPW-1:0] r_p;
    logic [SQW-1:0]        r_q;
    // L3: excess, exponent
    logic [XW-1:0]         r_x3;
    logic [SQW-1:0]        r_q3;
    logic [KW-1:0]         r_k3;
    logic                  r_z3;
    // carry chain through seed and Newton stages
    logic [31:0]           r_mc [NC];
    logic [XW-1:0]         r_xc [NC];
    logic [KW-1:0]         r_kc [NC];
    logic                  r_zc [NC];
    logic [31:0]           r_ya [NS+1];
    logic [31:0]           r_yb [NS];
    logic [31:0]           r_yc [NS];
    logic [31:0]           r_t  [NS];
    logic [31:0]           r_v  [NS];
    // tail
    logic [64:0]           r_pl;
    logic [XHW+31:0]       r_ph;
    logic [KW-1:0]         r_kp;
    logic                  r_zp;
    logic [W-1:0]          r_e;
    logic [2*W-1:0]        r_term;

    logic signed [SPW:0]   n_xa, n_xb;
    logic [XW-1:0]         n_x;
    logic [MBW-1:0]        n_msb;
    logic [SQW+31:0]       n_qs;
    logic [PRW-1:0]        n_prod, n_sh;
    logic [W-1:0]          n_e;

    always_comb begin
        n_xa = $signed({r_p[SPW-1], r_p}) - $signed({2'b00, r_q});
        n_xb = -$signed({r_p[SPW-1], r_p}) - $signed({2'b00, r_q});
        if (!n_xa[SPW])      n_x = n_xa[XW-1:0];
        else if (!n_xb[SPW]) n_x = n_xb[XW-1:0];
        else                 n_x = '0;
        n_msb = '0;
        for (int i = 0; i < SQW; i++) begin
            if (r_q[i]) n_msb = MBW'(i);
        end
    end

    // q * 2^(30-2k), truncating
    assign n_qs = {r_q3, 32'b0} >> ({r_k3, 1'b0} + 2);

    always_comb begin
        n_prod = {r_ph, 33'b0} + PRW'(r_pl);
        n_sh   = n_prod >> (r_kp + 30);
        if (n_sh > (PRW'(1) << (W-1))) n_e = W'(1) << (W-1);
        else                           n_e = n_sh[W-1:0];
        if (r_zp) n_e = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pd[i] <= i_d[i] * i_u[i];
                r_pq[i] <= i_u[i] * i_u[i];
            end
            r_p  <= SPW'(r_pd[0]) + SPW'(r_pd[1]) + SPW'(r_pd[2]);
            r_q  <= SQW'($unsigned(r_pq[0])) + SQW'($unsigned(r_pq[1]))
                  + SQW'($unsigned(r_pq[2]));
            r_x3 <= n_x;
            r_q3 <= r_q;
            r_k3 <= KW'(n_msb >> 1);
            r_z3 <= (r_q == '0);
            r_mc[0] <= n_qs[31:0];
            r_xc[0] <= r_x3;
            r_kc[0] <= r_k3;
            r_zc[0] <= r_z3;
            r_ya[0] <= seed_of(n_qs[31:29]);
            for (int s = 1; s < NC; s++) begin
                r_mc[s] <= r_mc[s-1];
                r_xc[s] <= r_xc[s-1];
                r_kc[s] <= r_kc[s-1];
                r_zc[s] <= r_zc[s-1];
            end
            r_pl <= 65'(r_xc[NC-1][32:0]) * 65'(r_ya[NS]);
            r_ph <= (XHW+32)'(r_xc[NC-1][XW-1:33]) * (XHW+32)'(r_ya[NS]);
            r_kp <= r_kc[NC-1];
            r_zp <= r_zc[NC-1];
            r_e  <= n_e;
            r_term <= (2*W)'(r_e) * (2*W)'(r_e);
        end
    end

    // Newton steps: t = y*y, v = 3 - m*t, y = y*v/2
    for (genvar j = 0; j < NS; j++) begin : g_newton
        logic [63:0] n_yy, n_mt, n_yv;
        logic [33:0] n_u;
        assign n_yy = 64'(r_ya[j]) * 64'(r_ya[j]);
        assign n_mt = 64'(r_mc[3*j+1]) * 64'(r_t[j]);
        assign n_u  = n_mt[63:30];
        assign n_yv = 64'(r_yc[j]) * 64'(r_v[j]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[j]    <= n_yy[61:30];
                r_yb[j]   <= r_ya[j];
                r_v[j]    <= (n_u < 34'h0_C000_0000) ? 32'(34'h0_C000_0000 - n_u) : 32'd0;
                r_yc[j]   <= r_yb[j];
                r_ya[j+1] <= n_yv[62:31];
            end
        end
    end

    assign o_term = r_term;

endmodule

>>> src/sphere_obb_intersect_test_top.sv
// Top level of the sphere versus oriented box overlap test.
// Accepts one box request per cycle while the result side keeps up and returns
// one overlap flag per box. The whole pipeline advances together: it moves
// whenever the output register is empty or being taken, so a box enters every
// cycle the result side keeps up. Each box passes through the per-axis chain:
// dot products, excess and exponent, table seed, three Newton steps for 1/sqrt
// of the squared axis length (three multiplies each), scaling and squaring;
// then one sum stage and one compare stage. Three identical lanes, one per box
// axis, run side by side. The sphere center and radius registers must only be
// written with the pipeline empty; radius squared is registered from the radius
// in the cycle after a write.
module sphere_obb_intersect_test_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [soit_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]         i_cfg_data,
    soit_box_if.sink                       i_box,
    soit_res_if.source                     o_res
);
    import soit_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int LAT = 19;

    logic signed [W-1:0]   r_scx, r_scy, r_scz;
    logic [W-2:0]          r_rad;
    logic [2*W-1:0]        r_r2;
    logic [LAT-1:0]        r_vld;
    logic signed [W:0]     r_d [3];
    logic signed [W-1:0]   r_u [3][3];
    logic [2*W-1:0]        w_term [3];
    logic [2*W-1:0]        r_sum;
    logic                  r_ovl;
    logic                  w_en;

    // stall the whole pipe only when a finished result is waiting
    assign w_en        = !r_vld[LAT-1] || o_res.ready;
    assign i_box.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scx <= '0;
            r_scy <= '0;
            r_scz <= '0;
            r_rad <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_scx <= i_cfg_data;
                CFG_CENTER_Y: r_scy <= i_cfg_data;
                CFG_CENTER_Z: r_scz <= i_cfg_data;
                CFG_RADIUS:   r_rad <= i_cfg_data[W-2:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= (2*W)'(r_rad) * (2*W)'(r_rad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_box.valid};
        end
    end

    // relative center d = sphere - box, one bit wider
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0] <= $signed({r_scx[W-1], r_scx}) - $signed({i_box.box_center_x[W-1],
                      i_box.box_center_x});
            r_d[1] <= $signed({r_scy[W-1], r_scy}) - $signed({i_box.box_center_y[W-1],
                      i_box.box_center_y});
            r_d[2] <= $signed({r_scz[W-1], r_scz}) - $signed({i_box.box_center_z[W-1],
                      i_box.box_center_z});
            r_u[0][0] <= i_box.axis_a_x;
            r_u[0][1] <= i_box.axis_a_y;
            r_u[0][2] <= i_box.axis_a_z;
            r_u[1][0] <= i_box.axis_b_x;
            r_u[1][1] <= i_box.axis_b_y;
            r_u[1][2] <= i_box.axis_b_z;
            r_u[2][0] <= i_box.axis_c_x;
            r_u[2][1] <= i_box.axis_c_y;
            r_u[2][2] <= i_box.axis_c_z;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_lane
        soit_lane #(.W(W)) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_d    (r_d),
            .i_u    (r_u[a]),
            .o_term (w_term[a])
        );
    end

    // merge: sum of squared distances, then compare with radius squared
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= w_term[0] + w_term[1] + w_term[2];
            r_ovl <= (r_sum <= r_r2);
        end
    end

    assign o_res.valid    = r_vld[LAT-1];
    assign o_res.overlaps = r_ovl;

endmodule

>>> src/soit_checker.sv
// Port-level checks for the sphere/box test, bound to the top level.
module soit_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_overlaps
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_overlaps))
        else $error("result dropped or changed while stalled");

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("request ready does not track output space");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid right after reset");

    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !(in_valid && in_ready))
        else $error("request taken while pipeline is stalled");
endmodule

bind sphere_obb_intersect_test_top soit_checker u_soit_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (i_box.valid),
    .in_ready     (i_box.ready),
    .out_valid    (o_res.valid),
    .out_ready    (o_res.ready),
    .out_overlaps (o_res.overlaps)
);
